/* design/dhtfd_pkg.sv */
// ----------------------------------------------------------------------------
// dhtfd_pkg
// Shared types and constants for the deduplicating hash table with its
// running FNV-1a-32 digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dhtfd_pkg;

  // FNV-1a-32 constants.
  localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  // Operation codes.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  // Command beat.
  typedef struct packed {
    logic        operation;
    logic [31:0] entry_hash;
    logic [7:0]  entry_type;
    logic [7:0]  slot_number;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [31:0] digest;
  } out_t;

endpackage

`default_nettype wire

/* design/dedup_hash_table_with_fnv_digest_core.sv */
// ----------------------------------------------------------------------------
// dedup_hash_table_with_fnv_digest_core
// Bounded table of 32-bit entry hashes with duplicate rejection and a
// running FNV-1a-32 digest over the stored entries.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on a rising edge where start is high and busy is
//   low. Each command gives exactly one result beat, shown on out_data for a
//   single cycle with out_valid high; the receiver must take it then.
//   A clear, or an add to a full table, answers in the cycle after it is
//   taken and leaves busy low, so such commands may follow every cycle.
//   An add to a table holding n entries scans the stored hashes through the
//   single memory read port, one per cycle, pipelined with one comparator.
//   A duplicate stops the scan early. A new entry is then written and folded
//   into the digest one byte per cycle through one 32x32 multiplier. The
//   result follows in the cycle after the last round, when busy is already
//   low again. Busy stays high through the scan and the fold, so no new
//   command is taken before an add has given its result.
//   Reset empties the table and restores the offset basis in the digest; no
//   clearing pass runs over the memory, as only written entries are compared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dedup_hash_table_with_fnv_digest_core #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire dhtfd_pkg::in_t  in_data,
  output logic                 out_valid,
  output dhtfd_pkg::out_t      out_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ENTRIES);
  localparam logic [2:0]       FOLD_LAST = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FOLD = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [31:0]       digest_r, digest_nxt;
  logic [31:0]       work_r, work_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [2:0]        fold_cnt_r, fold_cnt_nxt;
  dhtfd_pkg::in_t    cmd_r, cmd_nxt;
  logic              out_valid_r, out_valid_nxt;
  dhtfd_pkg::out_t   out_r, out_nxt;
  logic [31:0]       rd_data_r;
  logic              mem_we;
  logic [31:0]       count_ext;
  logic [31:0]       count_inc_ext;
  logic [7:0]        fold_byte;
  logic [31:0]       fold_mul;

  logic [31:0] hash_mem [MAX_ENTRIES];

  // Hash store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hash_mem[count_r[IDX_W-1:0]] <= cmd_r.entry_hash;
    end
    rd_data_r <= hash_mem[rd_idx_r[IDX_W-1:0]];
  end

  // Count as reported on the result, masked to seven bits.
  assign count_ext     = 32'(count_r);
  assign count_inc_ext = 32'(count_r + CNT_W'(1));

  // Byte fed into the digest in the current fold round.
  always_comb begin
    unique case (fold_cnt_r)
      3'd0:    fold_byte = cmd_r.entry_hash[7:0];
      3'd1:    fold_byte = cmd_r.entry_hash[15:8];
      3'd2:    fold_byte = cmd_r.entry_hash[23:16];
      3'd3:    fold_byte = cmd_r.entry_hash[31:24];
      3'd4:    fold_byte = cmd_r.entry_type;
      default: fold_byte = cmd_r.slot_number;
    endcase
  end

  // The shared multiplier: one FNV-1a round per cycle.
  assign fold_mul = 32'((work_r ^ {24'd0, fold_byte}) * dhtfd_pkg::FNV_PRIME);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    digest_nxt    = digest_r;
    work_nxt      = work_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    fold_cnt_nxt  = fold_cnt_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_data;
          if (in_data.operation == dhtfd_pkg::OP_CLEAR) begin
            count_nxt           = '0;
            digest_nxt          = dhtfd_pkg::FNV_BASIS;
            out_valid_nxt       = 1'b1;
            out_nxt.status      = dhtfd_pkg::ST_CLEARED;
            out_nxt.entry_count = '0;
            out_nxt.digest      = dhtfd_pkg::FNV_BASIS;
          end else if (count_r == CNT_MAX) begin
            out_valid_nxt       = 1'b1;
            out_nxt.status      = dhtfd_pkg::ST_FULL;
            out_nxt.entry_count = count_ext[6:0];
            out_nxt.digest      = digest_r;
          end else begin
            rd_idx_nxt  = '0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // A read issued last cycle is compared while the next one is issued.
        if (cmp_vld_r && (rd_data_r == cmd_r.entry_hash)) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = dhtfd_pkg::ST_DUP;
          out_nxt.entry_count = count_ext[6:0];
          out_nxt.digest      = digest_r;
          state_nxt           = S_IDLE;
        end else if ((rd_idx_r == count_r) && !cmp_vld_r) begin
          mem_we       = 1'b1;
          work_nxt     = digest_r;
          fold_cnt_nxt = '0;
          state_nxt    = S_FOLD;
        end else if (rd_idx_r != count_r) begin
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
      end

      S_FOLD: begin
        work_nxt     = fold_mul;
        fold_cnt_nxt = fold_cnt_r + 3'd1;
        if (fold_cnt_r == FOLD_LAST) begin
          digest_nxt          = fold_mul;
          count_nxt           = count_r + CNT_W'(1);
          out_valid_nxt       = 1'b1;
          out_nxt.status      = dhtfd_pkg::ST_ADDED;
          out_nxt.entry_count = count_inc_ext[6:0];
          out_nxt.digest      = fold_mul;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      digest_r    <= dhtfd_pkg::FNV_BASIS;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      digest_r    <= digest_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rd_idx_r   <= rd_idx_nxt;
    fold_cnt_r <= fold_cnt_nxt;
    cmd_r      <= cmd_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* design/dhtfd_chk.sv */
// ----------------------------------------------------------------------------
// dhtfd_chk
// Port-level checks for the deduplicating hash table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhtfd_chk #(
  parameter int MAX_ENTRIES = 64
) (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            start,
  input wire logic            busy,
  input wire dhtfd_pkg::in_t  in_data,
  input wire logic            out_valid,
  input wire dhtfd_pkg::out_t out_data
);

  localparam logic [6:0] MAX_CNT = 7'(MAX_ENTRIES);

  // No result beat follows a reset cycle.
  a_no_beat_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat in the cycle after reset");

  // A result is never shown while a command is still in progress.
  a_no_beat_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result beat while busy");

  // A clear answers at once with an empty table and the offset basis.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.operation == dhtfd_pkg::OP_CLEAR)) |=>
      (out_valid && (out_data.status == dhtfd_pkg::ST_CLEARED) &&
       (out_data.entry_count == 7'd0) && (out_data.digest == dhtfd_pkg::FNV_BASIS)))
    else $error("clear did not answer with an empty table");

  // A dropped entry is only ever reported with the table at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == dhtfd_pkg::ST_FULL)) |->
      (out_data.entry_count == MAX_CNT))
    else $error("table-full status below capacity");

  // A duplicate needs at least one stored entry.
  a_dup_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == dhtfd_pkg::ST_DUP)) |->
      (out_data.entry_count != 7'd0))
    else $error("duplicate reported on an empty table");

endmodule

bind dedup_hash_table_with_fnv_digest_core dhtfd_chk #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_dhtfd_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_data (out_data)
);

`default_nettype wire
